>>> rtl/s2c_pkg.sv
// ----------------------------------------------------------------------------
// s2c_pkg
// Shared constants, latencies and types for the spherical to Cartesian
// converter.
// ----------------------------------------------------------------------------
package s2c_pkg;

  localparam int unsigned ANGLE_BITS_DEF  = 16;
  localparam int unsigned RADIUS_BITS_DEF = 32;

  // Q.62 fixed point: 1.0 and pi/2
  localparam logic [63:0]  ONE_Q62     = 64'h4000_0000_0000_0000;
  localparam logic [63:0]  HALF_PI_Q62 = 64'h6487_ED51_10B4_611B;
  localparam logic [127:0] ROUND_HALF  = 128'h2000_0000_0000_0000;

  localparam int unsigned SERIES_TERMS = 12;

  // Pipeline latencies in clock cycles
  localparam int unsigned MUL_LAT  = 2;
  localparam int unsigned DIV_LAT  = MUL_LAT + 2;
  localparam int unsigned TERM_LAT = MUL_LAT + DIV_LAT + 1;
  localparam int unsigned TRIG_LAT = 1 + 2 * MUL_LAT + SERIES_TERMS * TERM_LAT + 1;
  localparam int unsigned TOP_LAT  = TRIG_LAT + 2 * MUL_LAT + 1;

  // Running state of the sine and cosine series
  typedef struct packed {
    logic [63:0] ts;
    logic [63:0] tc;
    logic [63:0] ss;
    logic [63:0] sc;
    logic [63:0] x2;
  } series_t;

  // Sine and cosine of one angle, sign and magnitude
  typedef struct packed {
    logic [63:0] smag;
    logic        sneg;
    logic [63:0] cmag;
    logic        cneg;
  } trig_t;

endpackage

>>> rtl/s2c_delay.sv
// ----------------------------------------------------------------------------
// s2c_delay
// Fixed-length shift line that carries side data alongside the pipeline.
// ----------------------------------------------------------------------------
module s2c_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] pipe [N];

  always_ff @(posedge clk) begin
    pipe[0] <= din;
    for (int i = 1; i < N; i++) begin
      pipe[i] <= pipe[i-1];
    end
  end

  assign dout = pipe[N-1];

endmodule

>>> rtl/s2c_mul64.sv
// ----------------------------------------------------------------------------
// s2c_mul64
// Two-stage 64 x 64 unsigned multiplier built from four 32 x 32 partials.
// ----------------------------------------------------------------------------
module s2c_mul64 (
  input  logic         clk,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] p
);

  logic [63:0] p00, p01, p10, p11;

  always_ff @(posedge clk) begin
    p00 <= a[31:0]  * b[31:0];
    p01 <= a[31:0]  * b[63:32];
    p10 <= a[63:32] * b[31:0];
    p11 <= a[63:32] * b[63:32];
  end

  always_ff @(posedge clk) begin
    p <= {p11, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0};
  end

endmodule

>>> rtl/s2c_cdiv.sv
// ----------------------------------------------------------------------------
// s2c_cdiv
// Exact floor division of a value below 2^62 by a constant, by reciprocal
// multiply and one correction step.
// ----------------------------------------------------------------------------
module s2c_cdiv #(
  parameter int unsigned D = 6
) (
  input  logic        clk,
  input  logic [63:0] n,
  output logic [63:0] q
);

  localparam int unsigned SH     = 62 + $clog2(D);
  localparam logic [127:0] M_WIDE = (128'd1 << SH) / D;
  localparam logic [63:0]  M      = M_WIDE[63:0];
  localparam logic [63:0]  D_W    = 64'(D);

  logic [127:0] prod;
  logic [127:0] prod_shr;
  logic [63:0]  qe;
  logic [63:0]  qe_r, qd_r;
  logic [63:0]  n_d1, n_d2, n_d3;
  logic [63:0]  rem;

  s2c_mul64 u_mul (.clk(clk), .a(n), .b(M), .p(prod));

  // estimate is the quotient or one below it
  assign prod_shr = prod >> SH;
  assign qe       = {2'b00, prod_shr[61:0]};

  always_ff @(posedge clk) begin
    n_d1 <= n;
    n_d2 <= n_d1;
    n_d3 <= n_d2;
    qe_r <= qe;
    qd_r <= qe * D_W;
  end

  assign rem = n_d3 - qd_r;

  always_ff @(posedge clk) begin
    q <= qe_r + {63'd0, (rem >= D_W)};
  end

endmodule

>>> rtl/s2c_term.sv
// ----------------------------------------------------------------------------
// s2c_term
// One Taylor step of the sine and cosine series for one angle.
// ----------------------------------------------------------------------------
module s2c_term #(
  parameter int unsigned K = 1
) (
  input  logic              clk,
  input  s2c_pkg::series_t  din,
  output s2c_pkg::series_t  dout
);

  localparam int unsigned DS  = (2 * K) * (2 * K + 1);
  localparam int unsigned DC  = (2 * K - 1) * (2 * K);
  localparam bit          SUB = (K % 2) == 1;

  logic [127:0]     ps, pc;
  logic [63:0]      qs, qc;
  s2c_pkg::series_t st_d;

  s2c_mul64 u_mul_s (.clk(clk), .a(din.ts), .b(din.x2), .p(ps));
  s2c_mul64 u_mul_c (.clk(clk), .a(din.tc), .b(din.x2), .p(pc));

  s2c_cdiv #(.D(DS)) u_div_s (.clk(clk), .n(ps[125:62]), .q(qs));
  s2c_cdiv #(.D(DC)) u_div_c (.clk(clk), .n(pc[125:62]), .q(qc));

  s2c_delay #(
    .W($bits(s2c_pkg::series_t)),
    .N(s2c_pkg::MUL_LAT + s2c_pkg::DIV_LAT)
  ) u_hold (.clk(clk), .din(din), .dout(st_d));

  // odd terms subtract, even terms add
  always_ff @(posedge clk) begin
    dout.ts <= qs;
    dout.tc <= qc;
    dout.x2 <= st_d.x2;
    dout.ss <= SUB ? (st_d.ss - qs) : (st_d.ss + qs);
    dout.sc <= SUB ? (st_d.sc - qc) : (st_d.sc + qc);
  end

endmodule

>>> rtl/s2c_trig.sv
// ----------------------------------------------------------------------------
// s2c_trig
// Pipelined sine and cosine of a binary angle: octant reduction, series
// and quadrant symmetry.
// ----------------------------------------------------------------------------
module s2c_trig #(
  parameter int unsigned ANGLE_BITS = s2c_pkg::ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic [ANGLE_BITS-1:0] ang,
  output s2c_pkg::trig_t        res
);

  localparam int unsigned QBITS = ANGLE_BITS - 2;
  localparam logic [QBITS:0]   QUARTER = {1'b1, {QBITS{1'b0}}};
  localparam logic [QBITS-1:0] HALF_Q  = {1'b1, {(QBITS - 1){1'b0}}};
  localparam int unsigned SIDE_LAT =
    2 * s2c_pkg::MUL_LAT + s2c_pkg::SERIES_TERMS * s2c_pkg::TERM_LAT;

  logic [QBITS-1:0] f;
  logic             swap;
  logic [QBITS:0]   f_sw;
  logic [QBITS-1:0] f_r;
  logic [1:0]       quad_r;
  logic             swap_r;
  logic [127:0]     px, px2;
  logic [63:0]      x, x_d, x2;
  logic [2:0]       side_d;
  logic [1:0]       quad_d;
  logic             swap_d;
  logic [63:0]      sy, cy;

  s2c_pkg::series_t series [s2c_pkg::SERIES_TERMS + 1];

  // fold the angle into the first octant of its quadrant
  assign f    = ang[QBITS-1:0];
  assign swap = f > HALF_Q;
  assign f_sw = QUARTER - {1'b0, f};

  always_ff @(posedge clk) begin
    f_r    <= swap ? f_sw[QBITS-1:0] : f;
    quad_r <= ang[ANGLE_BITS-1:ANGLE_BITS-2];
    swap_r <= swap;
  end

  s2c_mul64 u_mul_x (.clk(clk), .a(64'(f_r)), .b(s2c_pkg::HALF_PI_Q62), .p(px));
  assign x = px[QBITS+63:QBITS];

  s2c_mul64 u_mul_x2 (.clk(clk), .a(x), .b(x), .p(px2));
  assign x2 = px2[125:62];

  s2c_delay #(.W(64), .N(s2c_pkg::MUL_LAT)) u_x_hold (.clk(clk), .din(x), .dout(x_d));

  assign series[0] = '{ts: x_d, tc: s2c_pkg::ONE_Q62, ss: x_d,
                       sc: s2c_pkg::ONE_Q62, x2: x2};

  for (genvar k = 1; k <= s2c_pkg::SERIES_TERMS; k++) begin : g_term
    s2c_term #(.K(k)) u_term (.clk(clk), .din(series[k-1]), .dout(series[k]));
  end

  s2c_delay #(.W(3), .N(SIDE_LAT)) u_side (
    .clk (clk),
    .din ({quad_r, swap_r}),
    .dout(side_d)
  );
  assign quad_d = side_d[2:1];
  assign swap_d = side_d[0];

  assign sy = swap_d ? series[s2c_pkg::SERIES_TERMS].sc : series[s2c_pkg::SERIES_TERMS].ss;
  assign cy = swap_d ? series[s2c_pkg::SERIES_TERMS].ss : series[s2c_pkg::SERIES_TERMS].sc;

  always_ff @(posedge clk) begin
    unique case (quad_d)
      2'd0: begin
        res <= '{smag: sy, sneg: 1'b0, cmag: cy, cneg: 1'b0};
      end
      2'd1: begin
        res <= '{smag: cy, sneg: 1'b0, cmag: sy, cneg: 1'b1};
      end
      2'd2: begin
        res <= '{smag: sy, sneg: 1'b1, cmag: cy, cneg: 1'b1};
      end
      2'd3: begin
        res <= '{smag: cy, sneg: 1'b1, cmag: sy, cneg: 1'b0};
      end
    endcase
  end

endmodule

>>> rtl/spherical_to_cartesian.sv
// ----------------------------------------------------------------------------
// spherical_to_cartesian
// Converts (r, theta, phi) points to signed Q16.16 x, y, z coordinates.
// ----------------------------------------------------------------------------
// A point transfers in at every clock edge where start is high; busy is
// always low, so a point may follow in every cycle. Each result appears on
// x_coord, y_coord, z_coord and last_point_out for exactly one cycle with
// done high, in the order of the points. The latency is set mostly by the
// sine and cosine pipeline: twelve series steps, every step a 64-bit
// multiply, a reciprocal divide and an accumulate.
// The receiver cannot stall the block and none is needed: results are
// presented once and must be taken as they come.
// ----------------------------------------------------------------------------
module spherical_to_cartesian #(
  parameter int unsigned ANGLE_BITS  = s2c_pkg::ANGLE_BITS_DEF,
  parameter int unsigned RADIUS_BITS = s2c_pkg::RADIUS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [RADIUS_BITS-1:0]        radius,
  input  logic [ANGLE_BITS-1:0]         polar_angle,
  input  logic [ANGLE_BITS-1:0]         azimuth_angle,
  input  logic                          last_point,
  output logic                          done,
  output logic signed [RADIUS_BITS:0]   x_coord,
  output logic signed [RADIUS_BITS:0]   y_coord,
  output logic signed [RADIUS_BITS:0]   z_coord,
  output logic                          last_point_out
);

  localparam int unsigned OUT_BITS = RADIUS_BITS + 1;
  localparam int unsigned LAT      = s2c_pkg::TOP_LAT;

  s2c_pkg::trig_t         th, ph;
  logic [127:0]           pxp, pyp;
  logic [63:0]            ct_d;
  logic [RADIUS_BITS-1:0] r_d;
  logic [2:0]             neg_d;
  logic [127:0]           xr, yr, zr;
  logic [127:0]           xs, ys, zs;
  logic [LAT-1:0]         vpipe;
  logic                   last_d;

  // Negate a magnitude into the output width
  function automatic logic [OUT_BITS-1:0] enc(input logic [OUT_BITS-1:0] mag,
                                               input logic neg);
    return neg ? (~mag + 1'b1) : mag;
  endfunction

  // The pipeline never holds, so the block is never busy
  assign busy = 1'b0;

  // Advance a valid bit with every transfer; reset drops anything in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], start && !busy};
    end
  end
  assign done = vpipe[LAT-1];

  // Sine and cosine of both angles
  s2c_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_th (.clk(clk), .ang(polar_angle), .res(th));
  s2c_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_ph (.clk(clk), .ang(azimuth_angle), .res(ph));

  // Angular products for x and y, truncated to Q.62
  s2c_mul64 u_mul_cs (.clk(clk), .a(ph.cmag), .b(th.smag), .p(pxp));
  s2c_mul64 u_mul_ss (.clk(clk), .a(ph.smag), .b(th.smag), .p(pyp));

  // Hold cos(theta) level with the angular products
  s2c_delay #(.W(64), .N(s2c_pkg::MUL_LAT)) u_ct_hold (
    .clk(clk), .din(th.cmag), .dout(ct_d)
  );

  // Carry the signs across both multiply rounds
  s2c_delay #(.W(3), .N(2 * s2c_pkg::MUL_LAT)) u_sign_hold (
    .clk (clk),
    .din ({ph.cneg ^ th.sneg, ph.sneg ^ th.sneg, th.cneg}),
    .dout(neg_d)
  );

  // Hold the radius until the angular products are ready
  s2c_delay #(.W(RADIUS_BITS), .N(s2c_pkg::TRIG_LAT + s2c_pkg::MUL_LAT)) u_r_hold (
    .clk(clk), .din(radius), .dout(r_d)
  );

  // Scale by the radius
  s2c_mul64 u_mul_x (.clk(clk), .a(64'(r_d)), .b(pxp[125:62]), .p(xr));
  s2c_mul64 u_mul_y (.clk(clk), .a(64'(r_d)), .b(pyp[125:62]), .p(yr));
  s2c_mul64 u_mul_z (.clk(clk), .a(64'(r_d)), .b(ct_d), .p(zr));

  // Round half away from zero on the magnitude, then apply the sign
  assign xs = xr + s2c_pkg::ROUND_HALF;
  assign ys = yr + s2c_pkg::ROUND_HALF;
  assign zs = zr + s2c_pkg::ROUND_HALF;

  always_ff @(posedge clk) begin
    x_coord <= $signed(enc(xs[62+OUT_BITS-1:62], neg_d[2]));
    y_coord <= $signed(enc(ys[62+OUT_BITS-1:62], neg_d[1]));
    z_coord <= $signed(enc(zs[62+OUT_BITS-1:62], neg_d[0]));
  end

  // The last-point flag rides alongside the whole pipeline
  s2c_delay #(.W(1), .N(LAT)) u_last_hold (
    .clk(clk), .din(last_point), .dout(last_d)
  );
  assign last_point_out = last_d;

endmodule

>>> rtl/s2c_checker.sv
// ----------------------------------------------------------------------------
// s2c_checker
// Port-level checks of the converter's latency, flag, zero-radius and sign behaviour.
// ----------------------------------------------------------------------------
module s2c_checker #(
  parameter int unsigned ANGLE_BITS  = s2c_pkg::ANGLE_BITS_DEF,
  parameter int unsigned RADIUS_BITS = s2c_pkg::RADIUS_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [RADIUS_BITS-1:0]      radius,
  input logic [ANGLE_BITS-1:0]       polar_angle,
  input logic                        last_point,
  input logic                        done,
  input logic signed [RADIUS_BITS:0] x_coord,
  input logic signed [RADIUS_BITS:0] y_coord,
  input logic signed [RADIUS_BITS:0] z_coord,
  input logic                        last_point_out
);

  localparam int unsigned LAT = s2c_pkg::TOP_LAT;

  // every transfer in yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("result missing after transfer");

  // no result without a transfer in
  a_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without transfer");

  a_last: assert property (@(posedge clk) disable iff (rst)
    done |-> last_point_out == $past(last_point, LAT))
    else $error("last flag mismatch");

  a_zero_r: assert property (@(posedge clk) disable iff (rst)
    done && $past(radius == '0, LAT) |-> x_coord == '0 && y_coord == '0 && z_coord == '0)
    else $error("zero radius gives non-zero result");

  // theta in the first quadrant gives z >= 0
  a_z_sign: assert property (@(posedge clk) disable iff (rst)
    done && $past(polar_angle[ANGLE_BITS-1:ANGLE_BITS-2] == 2'd0, LAT)
      |-> !z_coord[RADIUS_BITS])
    else $error("z negative for theta below a quarter turn");

endmodule

bind spherical_to_cartesian s2c_checker #(
  .ANGLE_BITS (ANGLE_BITS),
  .RADIUS_BITS(RADIUS_BITS)
) u_s2c_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .radius        (radius),
  .polar_angle   (polar_angle),
  .last_point    (last_point),
  .done          (done),
  .x_coord       (x_coord),
  .y_coord       (y_coord),
  .z_coord       (z_coord),
  .last_point_out(last_point_out)
);

>>> sim/spherical_to_cartesian_test.sv
// ----------------------------------------------------------------------------
// spherical_to_cartesian_test
// Self-checking bench for the spherical to Cartesian converter. Points are
// sent through the start/busy handshake. A bit-exact fixed-point model of the
// sine, cosine and radius scaling predicts x, y, z and the last flag of every
// transfer, and each done strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module spherical_to_cartesian_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ANGLE_BITS  = 16;
  localparam int unsigned RADIUS_BITS = 32;
  localparam int unsigned OUT_W       = RADIUS_BITS + 1;
  localparam int unsigned QBITS       = ANGLE_BITS - 2;
  localparam logic [63:0] QUARTER     = 64'd1 << QBITS;
  localparam int unsigned N_RANDOM    = 985;
  localparam int unsigned REPORT_MAX  = 10;

  // One converted point as the block presents it
  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
    logic             last;
  } coords_t;

  // Holds the coordinates owed for every point transferred in, oldest first,
  // and checks each done strobe against the head of the queue.
  class coord_ledger;
    coords_t     coords_due[$];
    int unsigned points_noted;
    int unsigned coords_checked;
    int unsigned failures;

    // Product of two Q.62 magnitudes, truncated back to Q.62
    function logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
    endfunction

    // Sine and cosine of 0..pi/4 (Q.62 radians) by a truncated Taylor series
    function void octant_trig(input logic [63:0] x, output logic [63:0] s,
                              output logic [63:0] c);
      logic [63:0] x2;
      logic [63:0] ts;
      logic [63:0] tc;
      x2 = q62_mul(x, x);
      ts = x;
      s  = x;
      tc = s2c_pkg::ONE_Q62;
      c  = s2c_pkg::ONE_Q62;
      for (int k = 1; k <= s2c_pkg::SERIES_TERMS; k++) begin
        ts = q62_mul(ts, x2) / 64'((2 * k) * (2 * k + 1));
        tc = q62_mul(tc, x2) / 64'((2 * k - 1) * (2 * k));
        if (k % 2 == 1) begin
          s = s - ts;
          c = c - tc;
        end else begin
          s = s + ts;
          c = c + tc;
        end
      end
    endfunction

    // Fold the angle into one octant, evaluate, then restore quadrant signs
    function s2c_pkg::trig_t angle_trig(input logic [ANGLE_BITS-1:0] ang);
      s2c_pkg::trig_t t;
      logic [63:0]    f;
      logic [63:0]    x;
      logic [63:0]    sy;
      logic [63:0]    cy;
      logic [63:0]    hold;
      logic [127:0]   p;
      logic           swap;
      f    = 64'(ang[QBITS-1:0]);
      swap = f > (QUARTER >> 1);
      if (swap) f = QUARTER - f;
      p = {64'd0, f} * {64'd0, s2c_pkg::HALF_PI_Q62};
      x = p[QBITS+63:QBITS];
      octant_trig(x, sy, cy);
      if (swap) begin
        hold = sy;
        sy   = cy;
        cy   = hold;
      end
      case (ang[ANGLE_BITS-1 -: 2])
        2'd0:    t = '{smag: sy, sneg: 1'b0, cmag: cy, cneg: 1'b0};
        2'd1:    t = '{smag: cy, sneg: 1'b0, cmag: sy, cneg: 1'b1};
        2'd2:    t = '{smag: sy, sneg: 1'b1, cmag: cy, cneg: 1'b1};
        default: t = '{smag: cy, sneg: 1'b1, cmag: sy, cneg: 1'b0};
      endcase
      return t;
    endfunction

    // r * p / 2^62, half an LSB rounded away from zero on the magnitude
    function logic [63:0] radius_scaled(input logic [RADIUS_BITS-1:0] r,
                                        input logic [63:0] p);
      logic [127:0] acc;
      acc = {{(128 - RADIUS_BITS){1'b0}}, r} * {64'd0, p} + s2c_pkg::ROUND_HALF;
      return acc[125:62];
    endfunction

    // Apply the sign last; a negative zero comes out as plain zero
    function logic [OUT_W-1:0] to_coord(input logic [63:0] mag, input logic neg);
      logic [63:0] v;
      v = neg ? (64'd0 - mag) : mag;
      return v[OUT_W-1:0];
    endfunction

    function void note_point(input logic [RADIUS_BITS-1:0] r,
                             input logic [ANGLE_BITS-1:0] theta,
                             input logic [ANGLE_BITS-1:0] phi,
                             input logic last);
      s2c_pkg::trig_t tt;
      s2c_pkg::trig_t tp;
      coords_t        c;
      tt     = angle_trig(theta);
      tp     = angle_trig(phi);
      c.x    = to_coord(radius_scaled(r, q62_mul(tp.cmag, tt.smag)), tp.cneg ^ tt.sneg);
      c.y    = to_coord(radius_scaled(r, q62_mul(tp.smag, tt.smag)), tp.sneg ^ tt.sneg);
      c.z    = to_coord(radius_scaled(r, tt.cmag), tt.cneg);
      c.last = last;
      coords_due.push_back(c);
      points_noted++;
    endfunction

    function void check_coords(input logic [OUT_W-1:0] x, input logic [OUT_W-1:0] y,
                               input logic [OUT_W-1:0] z, input logic last);
      coords_t want;
      if (coords_due.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("%t: result with nothing outstanding: x=%h y=%h z=%h last=%b",
                   $realtime, x, y, z, last);
        return;
      end
      want = coords_due.pop_front();
      coords_checked++;
      if (x !== want.x || y !== want.y || z !== want.z || last !== want.last) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("%t: result %0d differs: want x=%h y=%h z=%h last=%b, got x=%h y=%h z=%h last=%b",
                   $realtime, coords_checked - 1, want.x, want.y, want.z, want.last,
                   x, y, z, last);
      end
    endfunction
  endclass

  logic                          clk           = 1'b0;
  logic                          rst           = 1'b1;
  logic                          start         = 1'b0;
  logic [RADIUS_BITS-1:0]        radius        = '0;
  logic [ANGLE_BITS-1:0]         polar_angle   = '0;
  logic [ANGLE_BITS-1:0]         azimuth_angle = '0;
  logic                          last_point    = 1'b0;
  logic                          busy;
  logic                          done;
  logic signed [RADIUS_BITS:0]   x_coord;
  logic signed [RADIUS_BITS:0]   y_coord;
  logic signed [RADIUS_BITS:0]   z_coord;
  logic                          last_point_out;

  coord_ledger ledger;
  bit          quiet_stretch = 1'b0;  // no sender gaps while set
  int unsigned n_directed    = 0;

  spherical_to_cartesian #(
    .ANGLE_BITS (ANGLE_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .radius        (radius),
    .polar_angle   (polar_angle),
    .azimuth_angle (azimuth_angle),
    .last_point    (last_point),
    .done          (done),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .z_coord       (z_coord),
    .last_point_out(last_point_out)
  );

  always #2 clk = ~clk;

  // Watch both sides at every edge. Inputs are driven with nonblocking
  // assignments on the same edge, so the values read here are those that
  // were set up before it: a transfer in is start high with busy low, and a
  // result is whatever sits on the ports while done is high.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        ledger.note_point(radius, polar_angle, azimuth_angle, last_point);
      if (done)
        ledger.check_coords(x_coord, y_coord, z_coord, last_point_out);
    end
  end

  // Present one point and hold it until the block takes it. Outside the quiet
  // stretch, drop start for a random gap now and then first, so that gaps
  // land at random points of the pipeline.
  task automatic send_point(input logic [RADIUS_BITS-1:0] r,
                            input logic [ANGLE_BITS-1:0] theta,
                            input logic [ANGLE_BITS-1:0] phi,
                            input logic last);
    if (!quiet_stretch && $urandom_range(99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    radius        <= r;
    polar_angle   <= theta;
    azimuth_angle <= phi;
    last_point    <= last;
    start         <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop sending and hold off until every owed result has come back
  task automatic drain_coords();
    start <= 1'b0;
    @(posedge clk);
    while (ledger.coords_due.size() != 0) @(posedge clk);
  endtask

  // Mostly uniform angles; one in four sits within two units of an octant
  // boundary, where the folding and quadrant logic switch over.
  function automatic logic [ANGLE_BITS-1:0] pick_angle();
    int unsigned base;
    if ($urandom_range(3) == 0) begin
      base = $urandom_range(7) << (ANGLE_BITS - 3);
      return ANGLE_BITS'(base + $urandom_range(4) - 2);
    end
    return ANGLE_BITS'($urandom());
  endfunction

  initial begin
    int unsigned            sel;
    logic [RADIUS_BITS-1:0] r;

    ledger = new;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed points: zero and full radius, each axis and quadrant edge,
    // the octant fold on both sides, and a tiny negative that rounds to zero.
    send_point('0,           16'h0000, 16'h0000, 1'b0);
    send_point('1,           16'h0000, 16'h0000, 1'b0);
    send_point('1,           16'h4000, 16'h0000, 1'b0);
    send_point('1,           16'h4000, 16'h4000, 1'b0);
    send_point('1,           16'h8000, 16'h8000, 1'b1);
    send_point('1,           16'hC000, 16'hC000, 1'b0);
    send_point('1,           16'h2000, 16'h2000, 1'b0);
    send_point('1,           16'h2001, 16'h1FFF, 1'b0);
    send_point('1,           16'hFFFF, 16'hFFFF, 1'b1);
    send_point(32'h0000_0001, 16'h4001, 16'h4001, 1'b0);
    send_point(32'h0000_0001, 16'hBFFF, 16'h7FFF, 1'b0);
    send_point(32'h0001_0000, 16'h2AAB, 16'h6000, 1'b1);
    send_point(32'h5555_AAAA, 16'h3FFF, 16'hA000, 1'b0);
    send_point(32'hAAAA_5555, 16'h6000, 16'hE000, 1'b0);
    send_point(32'h8000_0000, 16'h0001, 16'h8001, 1'b1);
    drain_coords();
    n_directed = ledger.points_noted;

    // Random points. Radius is mostly full range, with small, full-scale and
    // near-zero values mixed in. Hold back a long quiet stretch with no gaps,
    // and twice wait for the pipeline to empty completely.
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      quiet_stretch = (i >= 300 && i < 550);
      if (i == 150 || i == 700) drain_coords();
      sel = $urandom_range(9);
      if (sel < 6)       r = $urandom();
      else if (sel < 8)  r = $urandom_range(32'h3FFFF);
      else if (sel == 8) r = '1;
      else               r = $urandom_range(2);
      send_point(r, pick_angle(), pick_angle(), $urandom_range(7) == 0);
    end

    drain_coords();
    repeat (s2c_pkg::TOP_LAT + 20) @(posedge clk);
    if (ledger.coords_due.size() != 0) begin
      $display("%0d results never arrived", ledger.coords_due.size());
      ledger.failures += ledger.coords_due.size();
    end

    $display("Converted %0d points (%0d directed), radius zero to full scale, all quadrants",
             ledger.points_noted, n_directed);
    $display("Compared %0d results, %0d failures", ledger.coords_checked, ledger.failures);
    if (ledger.failures == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Guard against a hung handshake or missing results
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
